### rtl/lpht_pkg.sv
// shared types, sizes and helpers for the linear probing hash table
// no dependencies; used by every module of the block but lpht_ram
package lpht_pkg;

  localparam int TABLE_SIZE  = 29;
  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 64;
  localparam int VAL_W       = 64;
  localparam int SLOT_W      = 5;
  localparam int CMP_W       = 5;
  localparam int KEY_STORE_W = 8 * KEY_BYTES;
  localparam int ENTRY_W     = KEY_STORE_W + VAL_W;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int CNT_W       = $clog2(TABLE_SIZE + 1);
  localparam int SUM_W       = $clog2(KEY_BYTES * 255 + 1);
  localparam int MOD_W       = (SUM_W > CNT_W) ? SUM_W : CNT_W;
  // floor reciprocal, quotient estimate is at most one low
  localparam int RECIP_SHIFT = SUM_W + 9;
  localparam int RECIP       = (2 ** RECIP_SHIFT) / TABLE_SIZE;
  localparam int PROD_W      = SUM_W + RECIP_SHIFT;

  typedef enum logic [1:0] {
    OP_INSERT         = 2'd0,
    OP_INSERT_REPLACE = 2'd1,
    OP_FIND           = 2'd2,
    OP_DELETE         = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_MISSING = 3'd2,
    ST_DUP     = 3'd3,
    ST_ZERO    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SLOT_NONE = 2'd0,
    SLOT_HOME = 2'd1,
    SLOT_PTR  = 2'd2,
    SLOT_RD   = 2'd3
  } slot_sel_t;

  typedef struct packed {
    op_t              operation;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_index;
    logic [CMP_W-1:0]  comparisons;
    logic [VAL_W-1:0]  found_value;
  } rsp_t;

  typedef struct packed {
    logic      in_load;
    logic      hash_occ;
    logic      home_load;
    logic      ptr_init;
    logic      ptr_next;
    logic      ram_re;
    logic      ram_we;
    logic      addr_ptr;
    logic      wdata_pend;
    logic      used_set;
    logic      used_clr;
    logic      pend_in;
    logic      pend_ram;
    logic      res_load;
    status_t   res_status;
    slot_sel_t res_slot;
    logic      res_cnt;
    logic      res_fval;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic key_zero;
    logic home_used;
    logic key_match;
    logic rd_match;
    logic rd_last;
    logic occ_home_eq;
    logic cur_free;
    logic cur_last;
  } sts_t;

  function automatic logic [SUM_W-1:0] sum_bytes(input logic [KEY_STORE_W-1:0] k);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      s = s + SUM_W'(k[8*b +: 8]);
    end
    return s;
  endfunction

endpackage

### rtl/linear_probe_hash_table_unit.sv
// Key/value hash table with linear probing, 29 slots, 8-byte keys.
// Channels: req (operation, key, value) and rsp (status, slot_index,
// comparisons, found_value), each a valid/ready beat; one rsp beat per
// req beat, in order.
// A zero key is answered from the key check without hashing; an insert whose
// home slot is free is written there once hashing is done; find and delete
// scan after hashing (one slot read per cycle from the single port table ram),
// and an insert that swaps out the home occupant rehashes it and may probe the
// whole table (one occupancy bit checked per cycle).
// One item is in flight at a time; req_ready returns in the same cycle the
// result shows up in the output register.
// The output register holds a finished beat while the receiver stalls; the
// next request is still taken and worked on, and its result waits until the
// output register frees up.
// Reset (rst, synchronous) marks every slot free and drops any beat in
// flight; no clearing pass is needed.
// Depends on lpht_pkg, lpht_ctrl, lpht_dp and lpht_ram.
module linear_probe_hash_table_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  lpht_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output lpht_pkg::rsp_t rsp
);

  lpht_pkg::cmd_t cmd;
  lpht_pkg::sts_t sts;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpht_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

### rtl/lpht_ram.sv
// generic single port ram with registered read
// no dependencies
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/lpht_dp.sv
// datapath: key hashing, probe pointer, slot table, occupancy bits, result registers
// depends on lpht_pkg and lpht_ram
module lpht_dp (
  input  logic           clk,
  input  logic           rst,
  input  lpht_pkg::req_t req,
  input  lpht_pkg::cmd_t cmd,
  output lpht_pkg::sts_t sts,
  output lpht_pkg::rsp_t rsp
);

  lpht_pkg::op_t                     op_r;
  logic [lpht_pkg::KEY_STORE_W-1:0]  key_r;
  logic [lpht_pkg::VAL_W-1:0]        val_r;
  logic [lpht_pkg::KEY_STORE_W-1:0]  pend_key;
  logic [lpht_pkg::VAL_W-1:0]        pend_val;
  logic [lpht_pkg::SUM_W-1:0]        sum_r;
  logic [lpht_pkg::SUM_W-1:0]        sum_d;
  logic [lpht_pkg::SUM_W-1:0]        q_r;
  logic [lpht_pkg::IDX_W-1:0]        hash_r;
  logic [lpht_pkg::IDX_W-1:0]        home;
  logic [lpht_pkg::IDX_W-1:0]        ptr;
  logic [lpht_pkg::CNT_W-1:0]        cnt;
  logic [lpht_pkg::IDX_W-1:0]        rd_idx;
  logic [lpht_pkg::CNT_W-1:0]        rd_cnt;
  logic                              rd_used;
  logic [lpht_pkg::TABLE_SIZE-1:0]   used;
  lpht_pkg::rsp_t                    res;
  lpht_pkg::rsp_t                    out;

  logic [lpht_pkg::KEY_STORE_W-1:0]  hash_src;
  logic [lpht_pkg::PROD_W-1:0]       prod;
  logic [lpht_pkg::MOD_W-1:0]        rem;
  logic [lpht_pkg::MOD_W-1:0]        rem_fix;
  logic [lpht_pkg::IDX_W-1:0]        ram_addr;
  logic [lpht_pkg::ENTRY_W-1:0]      ram_wdata;
  logic [lpht_pkg::ENTRY_W-1:0]      ram_rdata;
  logic [lpht_pkg::KEY_STORE_W-1:0]  ram_key;
  logic [lpht_pkg::VAL_W-1:0]        ram_val;
  logic [lpht_pkg::IDX_W-1:0]        res_idx;

  assign ram_addr  = cmd.addr_ptr ? ptr : home;
  assign ram_wdata = cmd.wdata_pend ? {pend_key, pend_val} : {key_r, val_r};
  assign ram_key   = ram_rdata[lpht_pkg::ENTRY_W-1 -: lpht_pkg::KEY_STORE_W];
  assign ram_val   = ram_rdata[lpht_pkg::VAL_W-1:0];

  lpht_ram #(
    .WIDTH (lpht_pkg::ENTRY_W),
    .DEPTH (lpht_pkg::TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .re    (cmd.ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // home slot: byte sum, reciprocal quotient, remainder with one correction
  assign hash_src = cmd.hash_occ ? pend_key : key_r;
  assign prod     = lpht_pkg::PROD_W'(sum_r) * lpht_pkg::PROD_W'(lpht_pkg::RECIP);
  assign rem      = lpht_pkg::MOD_W'(sum_d)
                  - lpht_pkg::MOD_W'(q_r) * lpht_pkg::MOD_W'(lpht_pkg::TABLE_SIZE);
  assign rem_fix  = (rem >= lpht_pkg::MOD_W'(lpht_pkg::TABLE_SIZE))
                  ? rem - lpht_pkg::MOD_W'(lpht_pkg::TABLE_SIZE) : rem;

  always_ff @(posedge clk) begin
    sum_r  <= lpht_pkg::sum_bytes(hash_src);
    sum_d  <= sum_r;
    q_r    <= prod[lpht_pkg::PROD_W-1:lpht_pkg::RECIP_SHIFT];
    hash_r <= lpht_pkg::IDX_W'(rem_fix);
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_r  <= req.operation;
      key_r <= req.key[lpht_pkg::KEY_STORE_W-1:0];
      val_r <= req.value;
    end
    if (cmd.home_load) begin
      home <= hash_r;
    end
    if (cmd.ptr_init) begin
      ptr <= home;
      cnt <= '0;
    end else if (cmd.ptr_next) begin
      ptr <= (ptr == lpht_pkg::IDX_W'(lpht_pkg::TABLE_SIZE - 1)) ? '0 : ptr + 1'b1;
      cnt <= cnt + 1'b1;
    end
    if (cmd.ram_re) begin
      rd_idx  <= ram_addr;
      rd_cnt  <= cnt + 1'b1;
      rd_used <= used[ram_addr];
    end
    if (cmd.pend_in) begin
      pend_key <= key_r;
      pend_val <= val_r;
    end else if (cmd.pend_ram) begin
      pend_key <= ram_key;
      pend_val <= ram_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (cmd.used_set) begin
        used[ram_addr] <= 1'b1;
      end
      if (cmd.used_clr) begin
        used[rd_idx] <= 1'b0;
      end
    end
  end

  always_comb begin
    case (cmd.res_slot)
      lpht_pkg::SLOT_HOME: res_idx = home;
      lpht_pkg::SLOT_PTR:  res_idx = ptr;
      lpht_pkg::SLOT_RD:   res_idx = rd_idx;
      default:             res_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res.status      <= cmd.res_status;
      res.slot_index  <= lpht_pkg::SLOT_W'(res_idx);
      res.comparisons <= cmd.res_cnt ? lpht_pkg::CMP_W'(rd_cnt) : '0;
      res.found_value <= cmd.res_fval ? ram_val : '0;
    end
    if (cmd.out_load) begin
      out <= res;
    end
  end

  assign rsp = out;

  assign sts.op          = op_r;
  assign sts.key_zero    = (key_r == '0);
  assign sts.home_used   = used[home];
  assign sts.key_match   = (ram_key == key_r);
  assign sts.rd_match    = rd_used && (ram_key == key_r);
  assign sts.rd_last     = (rd_cnt == lpht_pkg::CNT_W'(lpht_pkg::TABLE_SIZE));
  assign sts.occ_home_eq = (hash_r == home);
  assign sts.cur_free    = !used[ptr];
  assign sts.cur_last    = (cnt == lpht_pkg::CNT_W'(lpht_pkg::TABLE_SIZE - 1));

  // a table write lands on a slot that is occupied or becomes so now
  a_write_occupied: assert property (@(posedge clk) disable iff (rst)
    cmd.ram_we |-> (cmd.used_set || used[ram_addr]))
    else $error("table write to a free slot without marking it used");

endmodule

### rtl/lpht_ctrl.sv
// controller state machine: sequences hashing, probing and scans, owns both handshakes
// depends on lpht_pkg
module lpht_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  lpht_pkg::sts_t sts,
  output lpht_pkg::cmd_t cmd
);

  typedef enum logic [15:0] {
    S_IDLE        = 16'h0001,
    S_CHECK       = 16'h0002,
    S_H1          = 16'h0004,
    S_H2          = 16'h0008,
    S_H3          = 16'h0010,
    S_DISPATCH    = 16'h0020,
    S_INS_CHK     = 16'h0040,
    S_O1          = 16'h0080,
    S_O2          = 16'h0100,
    S_O3          = 16'h0200,
    S_O4          = 16'h0400,
    S_PROBE_START = 16'h0800,
    S_PROBE       = 16'h1000,
    S_SCAN_START  = 16'h2000,
    S_SCAN        = 16'h4000,
    S_DONE        = 16'h8000
  } state_t;

  state_t state;
  state_t state_next;
  logic   evicted;
  logic   out_valid;
  logic   is_insert;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_valid;
  assign is_insert = (sts.op == lpht_pkg::OP_INSERT) ||
                     (sts.op == lpht_pkg::OP_INSERT_REPLACE);

  always_comb begin
    cmd            = '0;
    cmd.res_status = lpht_pkg::ST_OK;
    cmd.res_slot   = lpht_pkg::SLOT_NONE;
    cmd.hash_occ   = (state == S_O1);
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.in_load = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.key_zero) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = lpht_pkg::ST_ZERO;
          state_next     = S_DONE;
        end else begin
          state_next = S_H1;
        end
      end
      S_H1: state_next = S_H2;
      S_H2: state_next = S_H3;
      S_H3: begin
        cmd.home_load = 1'b1;
        state_next    = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (is_insert && !sts.home_used) begin
          cmd.ram_we   = 1'b1;
          cmd.used_set = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_slot = lpht_pkg::SLOT_HOME;
          state_next   = S_DONE;
        end else if (is_insert) begin
          cmd.ram_re = 1'b1;
          state_next = S_INS_CHK;
        end else begin
          cmd.ptr_init = 1'b1;
          state_next   = S_SCAN_START;
        end
      end
      S_INS_CHK: begin
        // home slot entry is on the ram output now
        if (sts.op == lpht_pkg::OP_INSERT_REPLACE && sts.key_match) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = lpht_pkg::ST_DUP;
          cmd.res_slot   = lpht_pkg::SLOT_HOME;
          state_next     = S_DONE;
        end else if (sts.op == lpht_pkg::OP_INSERT_REPLACE) begin
          cmd.pend_ram = 1'b1;
          state_next   = S_O1;
        end else begin
          cmd.pend_in  = 1'b1;
          cmd.ptr_init = 1'b1;
          state_next   = S_PROBE_START;
        end
      end
      S_O1: state_next = S_O2;
      S_O2: state_next = S_O3;
      S_O3: state_next = S_O4;
      S_O4: begin
        // occupant living away from its home gets swapped out
        if (!sts.occ_home_eq) begin
          cmd.ram_we = 1'b1;
        end else begin
          cmd.pend_in = 1'b1;
        end
        cmd.ptr_init = 1'b1;
        state_next   = S_PROBE_START;
      end
      S_PROBE_START: begin
        cmd.ptr_next = 1'b1;
        state_next   = S_PROBE;
      end
      S_PROBE: begin
        if (sts.cur_free) begin
          cmd.ram_we     = 1'b1;
          cmd.addr_ptr   = 1'b1;
          cmd.wdata_pend = 1'b1;
          cmd.used_set   = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_slot   = evicted ? lpht_pkg::SLOT_HOME : lpht_pkg::SLOT_PTR;
          state_next     = S_DONE;
        end else if (sts.cur_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = lpht_pkg::ST_FULL;
          cmd.res_slot   = evicted ? lpht_pkg::SLOT_HOME : lpht_pkg::SLOT_NONE;
          state_next     = S_DONE;
        end else begin
          cmd.ptr_next = 1'b1;
        end
      end
      S_SCAN_START: begin
        cmd.ram_re   = 1'b1;
        cmd.addr_ptr = 1'b1;
        cmd.ptr_next = 1'b1;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        // compare the slot read last cycle while the next read goes out
        if (sts.rd_match) begin
          cmd.res_load = 1'b1;
          cmd.res_slot = lpht_pkg::SLOT_RD;
          cmd.res_cnt  = 1'b1;
          cmd.res_fval = (sts.op == lpht_pkg::OP_FIND);
          cmd.used_clr = (sts.op == lpht_pkg::OP_DELETE);
          state_next   = S_DONE;
        end else if (sts.rd_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = lpht_pkg::ST_MISSING;
          cmd.res_cnt    = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.ram_re   = 1'b1;
          cmd.addr_ptr = 1'b1;
          cmd.ptr_next = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      evicted   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.in_load) begin
        evicted <= 1'b0;
      end else if (state == S_O4 && !sts.occ_home_eq) begin
        evicted <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_res_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> (state == S_DONE))
    else $error("result captured without moving to the output stage");

  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    cmd.ram_we |-> !cmd.ram_re)
    else $error("ram read and write in the same cycle");

  a_clear_on_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.used_clr |-> (sts.rd_match && sts.op == lpht_pkg::OP_DELETE))
    else $error("slot cleared without a delete hit");

endmodule

### test/lpht_table_checker.sv
`timescale 1ns / 100ps
// checker for the hash table unit: keeps its own copy of the table, predicts
// every response beat and compares it field by field; needs lpht_pkg
module lpht_table_checker
  import lpht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   mismatches,
  output int   outstanding,
  output int   results_seen,
  output int   full_seen
);

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

  logic             slot_full [TABLE_SIZE];
  logic [KEY_W-1:0] slot_k    [TABLE_SIZE];
  logic [VAL_W-1:0] slot_v    [TABLE_SIZE];
  rsp_t             pending_results [$];
  int               n_bad, n_rsp, n_full;

  function automatic int home_slot(logic [KEY_W-1:0] k);
    int sum;
    sum = 0;
    for (int b = 0; b < KEY_W / 8; b++) sum += int'(k[8*b +: 8]);
    return sum % TABLE_SIZE;
  endfunction

  function automatic void store_entry(int i, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    slot_full[i] = 1'b1;
    slot_k[i]    = k;
    slot_v[i]    = v;
  endfunction

  // updates the table copy and returns the response the op should produce
  function automatic rsp_t apply_table_op(req_t r);
    rsp_t             e;
    logic [KEY_W-1:0] k, mk;
    logic [VAL_W-1:0] mv;
    int               h, f, idx;
    bit               evicted, hit;
    e        = '0;
    e.status = ST_OK;
    k        = r.key & KEY_MASK;
    idx      = 0;
    if (k == '0) begin
      e.status = ST_ZERO;
      return e;
    end
    h = home_slot(k);
    if (r.operation == OP_INSERT || r.operation == OP_INSERT_REPLACE) begin
      if (!slot_full[h]) begin
        store_entry(h, k, r.value);
        e.slot_index = SLOT_W'(h);
      end else if (r.operation == OP_INSERT_REPLACE && slot_k[h] == k) begin
        e.status     = ST_DUP;
        e.slot_index = SLOT_W'(h);
      end else begin
        mk      = k;
        mv      = r.value;
        evicted = 1'b0;
        // occupant living away from its own home gets pushed out
        if (r.operation == OP_INSERT_REPLACE && home_slot(slot_k[h]) != h) begin
          mk = slot_k[h];
          mv = slot_v[h];
          store_entry(h, k, r.value);
          evicted = 1'b1;
        end
        // scan backward so the nearest free slot after home wins
        f = TABLE_SIZE;
        for (int d = TABLE_SIZE - 1; d >= 1; d--)
          if (!slot_full[(h + d) % TABLE_SIZE]) f = (h + d) % TABLE_SIZE;
        if (f < TABLE_SIZE) begin
          store_entry(f, mk, mv);
          e.slot_index = SLOT_W'(evicted ? h : f);
        end else begin
          e.status     = ST_FULL;
          e.slot_index = SLOT_W'(evicted ? h : 0);
        end
      end
    end else begin
      hit           = 1'b0;
      e.comparisons = CMP_W'(TABLE_SIZE);
      for (int d = 0; d < TABLE_SIZE && !hit; d++) begin
        idx = (h + d) % TABLE_SIZE;
        if (slot_full[idx] && slot_k[idx] == k) begin
          hit           = 1'b1;
          e.slot_index  = SLOT_W'(idx);
          e.comparisons = CMP_W'(d + 1);
        end
      end
      if (!hit) e.status = ST_MISSING;
      else if (r.operation == OP_FIND) e.found_value = slot_v[idx];
      else slot_full[idx] = 1'b0;
    end
    return e;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) slot_full[i] = 1'b0;
      pending_results.delete();
      n_bad  = 0;
      n_rsp  = 0;
      n_full = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        n_rsp++;
        if (rsp.status == ST_FULL) n_full++;
        if (pending_results.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("%0t: response beat with nothing pending: %p", $time, rsp);
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status || rsp.slot_index !== want.slot_index ||
              rsp.comparisons !== want.comparisons ||
              rsp.found_value !== want.found_value) begin
            n_bad++;
            if (n_bad <= 10)
              $display({"%0t: mismatch, expected status %0d slot %0d cmp %0d value %h,",
                        " got status %0d slot %0d cmp %0d value %h"}, $time,
                       want.status, want.slot_index, want.comparisons, want.found_value,
                       rsp.status, rsp.slot_index, rsp.comparisons, rsp.found_value);
          end
        end
      end
      if (req_valid && req_ready) pending_results.push_back(apply_table_op(req));
    end
    mismatches   <= n_bad;
    outstanding  <= pending_results.size();
    results_seen <= n_rsp;
    full_seen    <= n_full;
  end

endmodule

### test/tb_linear_probe_hash_table_unit.sv
`timescale 1ns / 100ps
// top of the hash table unit testbench: clock, reset, request and response
// pacing and the verdict; needs lpht_pkg, the unit and lpht_table_checker
module tb_linear_probe_hash_table_unit;
  import lpht_pkg::*;

  localparam int POOL_KEYS = 40;

  logic clk;
  logic rst = 1'b1;
  logic req_valid, req_ready, rsp_valid, rsp_ready;
  req_t req;
  rsp_t rsp;
  int   mismatches, outstanding, results_seen, full_seen;
  int   op_count [4];
  bit   tx_fast, rx_fast, hold_rx;
  logic [KEY_W-1:0] key_pool [POOL_KEYS];

  linear_probe_hash_table_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  lpht_table_checker table_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .full_seen    (full_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d responses still pending", outstanding);
    $display("== FAIL ==");
    $finish;
  end

  // mix of wide random keys, short ascii strings and single-byte keys, so
  // homes collide often and every key bit toggles
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    int               n;
    k = '0;
    case ($urandom_range(0, 3))
      0: k = {$urandom, $urandom};
      1: begin
        n = $urandom_range(1, 8);
        for (int b = 0; b < n; b++) k[8*b +: 8] = 8'($urandom_range(33, 126));
      end
      2: k = KEY_W'($urandom_range(1, 255));
      default: begin
        n = $urandom_range(0, 7);
        k[8*n +: 8] = 8'($urandom_range(1, 255));
      end
    endcase
    return k;
  endfunction

  task automatic issue_request(op_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{operation: op, key: k, value: v};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    op_count[int'(op)]++;
  endtask

  // response side pacing, with the occasional long hold-off
  initial begin
    int gap;
    rsp_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rx) begin
        hold_rx = 1'b0;
        rsp_ready <= 1'b0;
        for (int c = 0; c < 400; c++) @(posedge clk);
      end
      gap = rx_fast ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  initial begin
    op_t              op;
    logic [KEY_W-1:0] k;
    int               pick, w_ins, w_rep, w_find;
    req_valid = 1'b0;
    req       = '0;
    tx_fast   = 1'b0;
    rx_fast   = 1'b0;
    hold_rx   = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero key on every op, misses on an empty table
    issue_request(OP_INSERT, '0, {$urandom, $urandom});
    issue_request(OP_INSERT_REPLACE, '0, {$urandom, $urandom});
    issue_request(OP_FIND, '0, {$urandom, $urandom});
    issue_request(OP_DELETE, '0, {$urandom, $urandom});
    issue_request(OP_FIND, 64'h05, '0);
    issue_request(OP_DELETE, 64'h05, '0);
    // 0x05 and 0x22 share home 5, 0x06 then pushes 0x22 out of slot 6
    issue_request(OP_INSERT, 64'h05, {$urandom, $urandom});
    issue_request(OP_INSERT, 64'h22, {$urandom, $urandom});
    issue_request(OP_INSERT_REPLACE, 64'h06, {$urandom, $urandom});
    issue_request(OP_FIND, 64'h22, '0);
    issue_request(OP_INSERT_REPLACE, 64'h05, {$urandom, $urandom});
    issue_request(OP_INSERT, 64'h05, {$urandom, $urandom});
    issue_request(OP_DELETE, 64'h05, '0);
    issue_request(OP_FIND, 64'h05, '0);
    issue_request(OP_INSERT, '1, '1);
    issue_request(OP_FIND, '1, '0);
    issue_request(OP_INSERT, 64'h01, '0);
    issue_request(OP_INSERT_REPLACE, 64'h8000_0000_0000_0000, {$urandom, $urandom});
    // home 28 twice, the second wraps to slot 0
    issue_request(OP_INSERT, 64'h1c, {$urandom, $urandom});
    issue_request(OP_INSERT, 64'h39, {$urandom, $urandom});
    issue_request(OP_FIND, 64'h39, '0);
    issue_request(OP_DELETE, '1, '0);
    issue_request(OP_FIND, 64'h01, '1);

    for (int chunk = 0; chunk < 14; chunk++) begin
      if (chunk == 0 || $urandom_range(0, 2) == 0)
        foreach (key_pool[i]) key_pool[i] = random_key();
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      if (chunk == 3 || chunk == 9) begin
        hold_rx = 1'b1;
        tx_fast = 1'b1;
      end
      // fill, mixed, drain and replace-heavy profiles in turn
      case (chunk % 4)
        0: begin w_ins = 50; w_rep = 85; w_find = 93; end
        1: begin w_ins = 25; w_rep = 50; w_find = 75; end
        2: begin w_ins = 10; w_rep = 20; w_find = 55; end
        default: begin w_ins = 15; w_rep = 70; w_find = 85; end
      endcase
      for (int n = 0; n < 50; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < w_ins) op = OP_INSERT;
        else if (pick < w_rep) op = OP_INSERT_REPLACE;
        else if (pick < w_find) op = OP_FIND;
        else op = OP_DELETE;
        case ($urandom_range(0, 29))
          0: k = '0;
          1, 2: k = random_key();
          default: k = key_pool[$urandom_range(0, POOL_KEYS - 1)];
        endcase
        issue_request(op, k, {$urandom, $urandom});
      end
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d inserts, %0d replacing inserts, %0d finds, %0d deletes",
             op_count[OP_INSERT], op_count[OP_INSERT_REPLACE], op_count[OP_FIND],
             op_count[OP_DELETE]);
    $display("checked %0d response beats, %0d reporting a full table, %0d mismatches",
             results_seen, full_seen, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_dp.sv
rtl/lpht_ctrl.sv
rtl/linear_probe_hash_table_unit.sv
test/lpht_table_checker.sv
test/tb_linear_probe_hash_table_unit.sv
